/* src/cswq_pkg.sv */
`default_nettype none

package cswq_pkg;

  localparam int DEF_NUM_SEMS    = 16;
  localparam int DEF_QUEUE_DEPTH = 8;

  localparam int COUNT_W = 16;
  localparam int PID_W   = 8;
  localparam int IDX_W   = 4;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_POST   = 2'd1;
  localparam logic [1:0] OP_CREATE = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_SUSPEND = 2'd1;
  localparam logic [1:0] ACT_RESUME  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MAX  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] sem_index;
    logic [PID_W-1:0] caller_pid;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                action;
    logic [PID_W-1:0]          resumed_pid;
    logic [1:0]                status;
    logic signed [COUNT_W-1:0] count_after;
  } out_res_t;

  typedef struct packed {
    logic accept;     // capture request, read semaphore entry
    logic commit;     // write back entry, touch waiter store
    logic load_out;   // load result register from live result
    logic load_held;  // load result register from held result plus dequeued pid
  } dp_cmd_t;

  typedef struct packed {
    logic need_resume;
  } dp_sts_t;

endpackage

`default_nettype wire

/* src/cswq_ram.sv */
`default_nettype none

module cswq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/cswq_dp.sv */
`default_nettype none

module cswq_dp #(
  parameter int NUM_SEMS    = cswq_pkg::DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = cswq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cswq_pkg::in_req_t  in_req,
  input  wire cswq_pkg::dp_cmd_t  cmd,
  output cswq_pkg::dp_sts_t       sts,
  output cswq_pkg::out_res_t      out_res
);

  import cswq_pkg::*;

  localparam int SA = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int WD = NUM_SEMS * QUEUE_DEPTH;
  localparam int WA = (WD > 1) ? $clog2(WD) : 1;
  localparam int SW = COUNT_W + 2 * QA + OW;

  in_req_t           req_r;
  logic              bank_r;
  logic [NUM_SEMS-1:0] valid_r;
  out_res_t          res_r;
  out_res_t          out_r;

  logic [SA-1:0]     addr_r;
  logic [SW-1:0]     sem_q;
  logic [SW-1:0]     sem_cur;
  logic [SW-1:0]     sem_wr;
  logic [PID_W-1:0]  wait_q;
  logic [WA-1:0]     wbase;

  logic signed [COUNT_W-1:0] cnt_cur, cnt_new;
  logic [QA-1:0]     head_cur, head_new, tail_cur, tail_new;
  logic [OW-1:0]     occ_cur, occ_new;
  logic [1:0]        act_c, stat_c;
  logic              push_c, pop_c;
  out_res_t          res_c;
  out_res_t          held_c;

  function automatic logic [QA-1:0] slot_adv(input logic [QA-1:0] s);
    logic [QA-1:0] r;
    if (s == QA'(QUEUE_DEPTH - 1)) r = '0;
    else r = s + 1'b1;
    return r;
  endfunction

  assign addr_r = SA'(req_r.sem_index);

  // entries not yet written read as the reset state
  assign sem_cur  = valid_r[addr_r] ? sem_q : '0;
  assign cnt_cur  = sem_cur[SW-1 -: COUNT_W];
  assign head_cur = sem_cur[2*QA+OW-1 -: QA];
  assign tail_cur = sem_cur[QA+OW-1 -: QA];
  assign occ_cur  = sem_cur[OW-1:0];

  always_comb begin
    cnt_new  = cnt_cur;
    head_new = head_cur;
    tail_new = tail_cur;
    occ_new  = occ_cur;
    act_c    = ACT_NONE;
    stat_c   = ST_OK;
    push_c   = 1'b0;
    pop_c    = 1'b0;
    case (req_r.operation)
      OP_WAIT: begin
        if (cnt_cur <= 16'sd0) begin
          if (occ_cur >= OW'(QUEUE_DEPTH) || cnt_cur == COUNT_MIN) begin
            stat_c = ST_FULL;
          end else begin
            cnt_new  = cnt_cur - 16'sd1;
            tail_new = slot_adv(tail_cur);
            occ_new  = occ_cur + 1'b1;
            act_c    = ACT_SUSPEND;
            push_c   = 1'b1;
          end
        end else begin
          cnt_new = cnt_cur - 16'sd1;
        end
      end
      OP_POST: begin
        if (cnt_cur == COUNT_MAX) begin
          stat_c = ST_MAX;
        end else begin
          cnt_new = cnt_cur + 16'sd1;
          if (cnt_new <= 16'sd0 && occ_cur != '0) begin
            head_new = slot_adv(head_cur);
            occ_new  = occ_cur - 1'b1;
            act_c    = ACT_RESUME;
            pop_c    = 1'b1;
          end
        end
      end
      OP_CREATE: begin
        cnt_new  = '0;
        head_new = '0;
        tail_new = '0;
        occ_new  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_c             = '0;
    res_c.action      = bank_r ? act_c : ACT_NONE;
    res_c.status      = bank_r ? stat_c : ST_OK;
    res_c.count_after = bank_r ? cnt_new : '0;
    held_c             = res_r;
    held_c.resumed_pid = wait_q;
  end

  assign sts.need_resume = bank_r && pop_c;
  assign sem_wr = {cnt_new, head_new, tail_new, occ_new};
  assign wbase  = WA'(addr_r) * WA'(QUEUE_DEPTH);

  cswq_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_SEMS)
  ) u_sem_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && bank_r),
    .wr_addr (addr_r),
    .wr_data (sem_wr),
    .rd_en   (cmd.accept),
    .rd_addr (SA'(in_req.sem_index)),
    .rd_data (sem_q)
  );

  cswq_ram #(
    .WIDTH (PID_W),
    .DEPTH (WD)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && bank_r && push_c),
    .wr_addr (wbase + WA'(tail_cur)),
    .wr_data (req_r.caller_pid),
    .rd_en   (cmd.commit && bank_r && pop_c),
    .rd_addr (wbase + WA'(head_cur)),
    .rd_data (wait_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && bank_r) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= in_req;
      bank_r <= (32'(in_req.sem_index) < NUM_SEMS);
    end
    if (cmd.commit) begin
      res_r <= res_c;
    end
    if (cmd.load_out) begin
      out_r <= res_c;
    end else if (cmd.load_held) begin
      out_r <= held_c;
    end
  end

  assign out_res = out_r;

endmodule

`default_nettype wire

/* src/cswq_ctrl.sv */
`default_nettype none

module cswq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire cswq_pkg::dp_sts_t sts,
  output cswq_pkg::dp_cmd_t      cmd
);

  import cswq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_RESUME
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CALC;
        end
      end
      S_CALC: begin
        // a resume passes through S_RESUME for the waiter read
        if (sts.need_resume) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESUME;
        end else if (out_free) begin
          cmd.commit    = 1'b1;
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RESUME: begin
        if (out_free) begin
          cmd.load_held = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* src/counting_semaphore_wait_queue.sv */
// Bank of counting semaphores, each with a FIFO of waiting pids.
// Input channel (in_valid/in_stall/in_req): one request names a semaphore
// and is a wait, post or create. Output channel (out_valid/out_stall/
// out_res): exactly one result per request, in request order.
// A request is taken in S_IDLE, where its semaphore entry is read; S_CALC
// registers its result, and a post that wakes a waiter passes S_RESUME for
// the waiter store read that follows the semaphore entry read. The next
// request waits until the current one is done, set by the read-modify-write
// of the semaphore entry RAM through its single registered read port.
// in_stall is high while a request is being worked; the next request is
// taken while a finished result still waits in the output register.
// A stalled result holds; the block then finishes its current request only
// once the output register is free.
// Reset (rst_n low, synchronous) empties the pipeline and marks every
// semaphore as count zero with an empty queue at once; the waiter store is
// not cleared, as only occupied slots are ever read.
`default_nettype none

module counting_semaphore_wait_queue #(
  parameter int NUM_SEMS    = cswq_pkg::DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = cswq_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cswq_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cswq_pkg::out_res_t      out_res
);

  import cswq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cswq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cswq_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule

`default_nettype wire
